[rtl/cds_pkg.sv]
`timescale 1ns / 1ps
// cds_pkg: shared types, constants and calendar helpers for the date stepper
// no dependencies; imported by cds_loader, cds_step_unit and calendar_date_stepper

package cds_pkg;

  localparam int DEF_YEAR_BITS  = 12;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [11:0] YEAR_SET_MIN = 12'd1900;
  localparam logic [11:0] YEAR_SET_MAX = 12'd2100;
  localparam logic [11:0] YEAR_2000    = 12'd2000;
  localparam logic [3:0]  MONTHS       = 4'd12;
  localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;
  localparam logic [6:0]  LAST_MOD100  = 7'd99;
  localparam logic [1:0]  CENT_1900    = 2'd3;
  localparam logic [1:0]  CENT_2000    = 2'd0;
  localparam logic [1:0]  CENT_2100    = 2'd1;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_INC = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;
  localparam logic [1:0] OP_ADD = 2'd3;

  // date without the year: year mod 100 and century mod 4 carry the leap rule
  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] mod100;
    logic [1:0] cent;
  } cal_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic is_leap(input logic [6:0] mod100, input logic [1:0] cent,
                                   input logic [1:0] low2);
    logic lp;
    if (mod100 == 7'd0) begin
      lp = (cent == 2'd0);
    end else begin
      lp = (low2 == 2'd0);
    end
    return lp;
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == 4'd2 && leap) begin
      len = FEB_LEAP_LEN;
    end else begin
      len = month_len(m);
    end
    return len;
  endfunction

endpackage

[rtl/calendar_date_stepper.sv]
`timescale 1ns / 1ps
// calendar_date_stepper: Gregorian date register stepped by one command per transfer
// depends on cds_pkg, cds_loader and cds_step_unit
//
// usage
//   slave channel s_tvalid/s_tready/s_tdata carries one command per transfer:
//   set date, increment day, decrement day, or add day_count days
//   master channel m_tvalid/m_tready/m_tdata returns one result per command,
//   the date before and after the command
//   set, increment, decrement and add with a zero count load their result into
//   the output register at the transfer when it is free, and s_tready stays
//   high, so these run at one per cycle while the receiver keeps up
//   add with a count of n runs the step unit once per day in the run state,
//   with s_tready low until the result is loaded; once the date has settled
//   the result waits in the block until the output register is free
//   the output register holds a result until taken; a command can still be
//   accepted while it waits, and the next result waits in the block meanwhile
//   a stalled receiver therefore stops input after one extra command
//   reset (rst, synchronous) loads 1 January 1900 and empties the output
//   there is no clearing pass; the block is ready the cycle after reset

module calendar_date_stepper #(
  parameter int YEAR_BITS  = cds_pkg::DEF_YEAR_BITS,
  parameter int COUNT_BITS = cds_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // op[1:0] month_in[5:2] day_in[10:6]
                                 // year_in[22:11] day_count[38:23]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // old_day[4:0] old_month[8:5] old_year[20:9]
                                 // new_day[25:21] new_month[29:26] new_year[41:30]
);
  import cds_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  cal_t                  cur;
  cal_t                  cur_next;
  logic [YEAR_BITS-1:0]  cur_year;
  logic [YEAR_BITS-1:0]  cur_year_next;
  logic [COUNT_BITS-1:0] cnt;
  logic [4:0]            old_day;
  logic [3:0]            old_month;
  logic [11:0]           old_year;

  logic [1:0]            op;
  logic [3:0]            month_in;
  logic [4:0]            day_in;
  logic [11:0]           year_in;
  logic [15:0]           day_count;
  logic [COUNT_BITS-1:0] cnt_load;

  cal_t                  set_cal;
  logic [YEAR_BITS-1:0]  set_year;
  cal_t                  step_cal;
  logic [YEAR_BITS-1:0]  step_year;
  logic                  step_back;

  logic                  accept;
  logic                  go_run;
  logic                  out_free;
  logic                  load_out;

  assign op        = s_tdata[1:0];
  assign month_in  = s_tdata[5:2];
  assign day_in    = s_tdata[10:6];
  assign year_in   = s_tdata[22:11];
  assign day_count = s_tdata[38:23];
  assign cnt_load  = COUNT_BITS'(day_count);

  cds_loader #(.YEAR_BITS(YEAR_BITS)) u_loader (
    .month_in (month_in),
    .day_in   (day_in),
    .year_in  (year_in),
    .cal      (set_cal),
    .year     (set_year)
  );

  assign step_back = (state == ST_IDLE) && (op == OP_DEC);

  cds_step_unit #(.YEAR_BITS(YEAR_BITS)) u_step (
    .back      (step_back),
    .cal       (cur),
    .year      (cur_year),
    .cal_next  (step_cal),
    .year_next (step_year)
  );

  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign go_run   = (op == OP_ADD) && (cnt_load != '0);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    cur_year_next = cur_year;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_SET: begin
              cur_next      = set_cal;
              cur_year_next = set_year;
            end
            OP_INC, OP_DEC: begin
              cur_next      = step_cal;
              cur_year_next = step_year;
            end
            default: begin
            end
          endcase
          if (go_run) begin
            state_next = ST_RUN;
          end else if (out_free) begin
            load_out = 1'b1;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        cur_next      = step_cal;
        cur_year_next = step_year;
        if (cnt == COUNT_BITS'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur.day    <= 5'd1;
      cur.month  <= 4'd1;
      cur.mod100 <= 7'd0;
      cur.cent   <= CENT_1900;
      cur_year   <= YEAR_BITS'(YEAR_SET_MIN);
      cnt        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      cur_year <= cur_year_next;
      if (accept) begin
        cnt <= cnt_load;
      end else if (state == ST_RUN) begin
        cnt <= cnt - COUNT_BITS'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      old_day   <= cur.day;
      old_month <= cur.month;
      old_year  <= cur_year[11:0];
    end
    if (load_out) begin
      if (state == ST_IDLE) begin
        m_tdata <= {6'd0, cur_year_next[11:0], cur_next.month, cur_next.day,
                    cur_year[11:0], cur.month, cur.day};
      end else begin
        m_tdata <= {6'd0, cur_year[11:0], cur.month, cur.day,
                    old_year, old_month, old_day};
      end
    end
  end

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt != '0))
    else $error("add-days running with a zero count");

  a_run_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && cnt == COUNT_BITS'(1)) |=> (state == ST_DONE))
    else $error("add-days did not finish on its last day");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (cur.month >= 4'd1 && cur.month <= MONTHS && cur.day >= 5'd1 && cur.mod100 <= LAST_MOD100))
    else $error("current date out of range");

  a_day_fits: assert property (@(posedge clk) disable iff (rst)
    (cur.day <= days_in(cur.month, is_leap(cur.mod100, cur.cent, cur_year[1:0]))))
    else $error("day beyond month length");

endmodule

[rtl/cds_loader.sv]
`timescale 1ns / 1ps
// cds_loader: validates a date for the set command and derives its leap tracking
// depends on cds_pkg

module cds_loader #(
  parameter int YEAR_BITS = cds_pkg::DEF_YEAR_BITS
) (
  input  logic [3:0]           month_in,
  input  logic [4:0]           day_in,
  input  logic [11:0]          year_in,
  output cds_pkg::cal_t        cal,
  output logic [YEAR_BITS-1:0] year
);
  import cds_pkg::*;

  logic [3:0]  m;
  logic [11:0] y;
  logic [11:0] rel;
  logic [1:0]  cent;
  logic [4:0]  dim;

  assign m = (month_in >= 4'd1 && month_in <= MONTHS) ? month_in : 4'd1;
  assign y = (year_in >= YEAR_SET_MIN && year_in <= YEAR_SET_MAX) ? year_in : YEAR_SET_MIN;

  always_comb begin
    if (y < YEAR_2000) begin
      rel  = y - YEAR_SET_MIN;
      cent = CENT_1900;
    end else if (y < YEAR_SET_MAX) begin
      rel  = y - YEAR_2000;
      cent = CENT_2000;
    end else begin
      rel  = 12'd0;
      cent = CENT_2100;
    end
  end

  assign dim = days_in(m, is_leap(rel[6:0], cent, y[1:0]));

  assign cal.month  = m;
  assign cal.mod100 = rel[6:0];
  assign cal.cent   = cent;
  assign cal.day    = (day_in >= 5'd1 && day_in <= dim) ? day_in : 5'd1;
  assign year       = YEAR_BITS'(y);

endmodule

[rtl/cds_step_unit.sv]
`timescale 1ns / 1ps
// cds_step_unit: shared one-day step forward or back across month and year edges
// depends on cds_pkg

module cds_step_unit #(
  parameter int YEAR_BITS = cds_pkg::DEF_YEAR_BITS
) (
  input  logic                 back,
  input  cds_pkg::cal_t        cal,
  input  logic [YEAR_BITS-1:0] year,
  output cds_pkg::cal_t        cal_next,
  output logic [YEAR_BITS-1:0] year_next
);
  import cds_pkg::*;

  localparam logic [YEAR_BITS-1:0] YEAR_TOP = {YEAR_BITS{1'b1}};
  localparam int YEAR_TOP_INT = (1 << YEAR_BITS) - 1;
  localparam logic [6:0] TOP_MOD100 = 7'(YEAR_TOP_INT % 100);
  localparam logic [1:0] TOP_CENT   = 2'((YEAR_TOP_INT / 100) % 4);

  logic       leap;
  logic [3:0] prev_month;

  assign leap       = is_leap(cal.mod100, cal.cent, year[1:0]);
  assign prev_month = cal.month - 4'd1;

  always_comb begin
    cal_next  = cal;
    year_next = year;
    if (!back) begin
      if (cal.day < days_in(cal.month, leap)) begin
        cal_next.day = cal.day + 5'd1;
      end else if (cal.month < MONTHS) begin
        cal_next.month = cal.month + 4'd1;
        cal_next.day   = 5'd1;
      end else begin
        cal_next.month = 4'd1;
        cal_next.day   = 5'd1;
        year_next      = year + YEAR_BITS'(1);
        if (year == YEAR_TOP) begin
          cal_next.mod100 = 7'd0;
          cal_next.cent   = 2'd0;
        end else if (cal.mod100 == LAST_MOD100) begin
          cal_next.mod100 = 7'd0;
          cal_next.cent   = cal.cent + 2'd1;
        end else begin
          cal_next.mod100 = cal.mod100 + 7'd1;
        end
      end
    end else begin
      if (cal.day > 5'd1) begin
        cal_next.day = cal.day - 5'd1;
      end else if (cal.month > 4'd1) begin
        cal_next.month = prev_month;
        cal_next.day   = days_in(prev_month, leap);
      end else begin
        cal_next.month = MONTHS;
        cal_next.day   = 5'd31;
        year_next      = year - YEAR_BITS'(1);
        if (year == '0) begin
          cal_next.mod100 = TOP_MOD100;
          cal_next.cent   = TOP_CENT;
        end else if (cal.mod100 == 7'd0) begin
          cal_next.mod100 = LAST_MOD100;
          cal_next.cent   = cal.cent - 2'd1;
        end else begin
          cal_next.mod100 = cal.mod100 - 7'd1;
        end
      end
    end
  end

endmodule
